// ===== hdl/ptb_pkg.sv =====
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

   // Field widths of the command and result words.
   localparam int OP_W      = 3;
   localparam int IDX_W     = 3;
   localparam int PERIOD_W  = 32;
   localparam int ELAPSED_W = 16;
   localparam int COUNT_W   = 18;

   // Command queue between the decoder and the executor.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Operation codes as they arrive on the request port.
   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_QRUN  = 3'd3,
      OP_QEXP  = 3'd4,
      OP_QPER  = 3'd5
   } op_type;

   // Decoded command class; unknown codes, out-of-range slots and empty ticks become K_NOP.
   typedef enum logic [2:0] {
      K_NOP,
      K_TICK,
      K_START,
      K_STOP,
      K_QRUN,
      K_QEXP,
      K_QPER
   } kind_type;

   // One decoded command word as it travels through the queue.
   typedef struct packed {
      kind_type               kind;
      logic [IDX_W-1:0]       slot;
      logic [PERIOD_W-1:0]    period;
      logic [ELAPSED_W-1:0]   elapsed;
   } cmd_type;

   // Per-slot count memory word.
   typedef struct packed {
      logic [COUNT_W-1:0] reload;
      logic [COUNT_W-1:0] remain;
   } cnt_type;

   // Executor states.
   typedef enum logic [1:0] {
      B_IDLE,
      B_SWEEP,
      B_DIV,
      B_QPER
   } back_state_type;

endpackage

// ===== hdl/periodic_timer_bank_core.sv =====
// Top level of the periodic timer bank: decoder, command queue and executor.
//
// A bank of NUM_TIMERS auto-reloading timers stepped by tick commands. A command
// word is taken when start is high and busy is low; busy rises only when the
// two-word command queue is full. Every command returns exactly one result word,
// shown for one cycle with rsp_valid; the receiver cannot stall, so results must
// be captured when they appear. Executor work per command: stop, running and
// expired queries, unknown codes and ticks of zero elapsed ticks finish at
// dispatch; a period query waits for the registered period memory read; a tick
// runs dispatch, one slot read per cycle through the count memory, and the
// write-back of the last slot; a start waits on the two-stage reciprocal
// multiplier that computes the interval. The result word is registered, so it
// appears in the cycle after the command completes.
module periodic_timer_bank_core
   import ptb_pkg::*;
#(
   parameter int NUM_TIMERS = 8,
   parameter int TICK_US    = 31250
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [IDX_W-1:0]     req_timer_index,
   input  logic [PERIOD_W-1:0]  req_period_us,
   input  logic [ELAPSED_W-1:0] req_elapsed_ticks,
   output logic                 rsp_valid,
   output logic                 rsp_is_expired,
   output logic                 rsp_is_running,
   output logic [PERIOD_W-1:0]  rsp_stored_period_us
);

   logic    fifo_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_vld;
   cmd_type head;

   // Decode incoming words.
   ptb_front #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_front (
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_timer_index   (req_timer_index),
      .req_period_us     (req_period_us),
      .req_elapsed_ticks (req_elapsed_ticks),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // Decouple decode from execution.
   ptb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (fifo_full),
      .head_vld (head_vld),
      .head     (head)
   );

   // Execute commands against the timer state.
   ptb_back #(
      .NUM_TIMERS (NUM_TIMERS),
      .TICK_US    (TICK_US)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_vld             (head_vld),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_is_expired       (rsp_is_expired),
      .rsp_is_running       (rsp_is_running),
      .rsp_stored_period_us (rsp_stored_period_us)
   );

endmodule

// ===== hdl/ptb_front.sv =====
// Request decoder: accepts command words and classifies them for the queue.
module ptb_front
   import ptb_pkg::*;
#(
   parameter int NUM_TIMERS = 8
) (
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [IDX_W-1:0]     req_timer_index,
   input  logic [PERIOD_W-1:0]  req_period_us,
   input  logic [ELAPSED_W-1:0] req_elapsed_ticks,
   input  logic                 fifo_full,
   output logic                 push,
   output cmd_type              push_cmd
);

   logic     slot_ok;
   kind_type kind;

   // Hold off new words while the queue is full.
   assign busy = fifo_full;
   assign push = start && !fifo_full;

   // Classify the operation; out-of-range slots and empty ticks do nothing.
   always_comb begin
      slot_ok = int'(req_timer_index) < NUM_TIMERS;
      case (op_type'(req_operation))
         OP_TICK:  kind = (req_elapsed_ticks == '0) ? K_NOP : K_TICK;
         OP_START: kind = slot_ok ? K_START : K_NOP;
         OP_STOP:  kind = slot_ok ? K_STOP  : K_NOP;
         OP_QRUN:  kind = slot_ok ? K_QRUN  : K_NOP;
         OP_QEXP:  kind = slot_ok ? K_QEXP  : K_NOP;
         OP_QPER:  kind = slot_ok ? K_QPER  : K_NOP;
         default:  kind = K_NOP;
      endcase
   end

   // Pack the decoded word.
   always_comb begin
      push_cmd.kind    = kind;
      push_cmd.slot    = req_timer_index;
      push_cmd.period  = req_period_us;
      push_cmd.elapsed = req_elapsed_ticks;
   end

endmodule

// ===== hdl/ptb_fifo.sv =====
// Short command queue between the decoder and the executor.
module ptb_fifo
   import ptb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_vld,
   output cmd_type head
);

   cmd_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  cnt_ff, cnt_in;

   assign full     = cnt_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign head_vld = cnt_ff != '0;
   assign head     = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/ptb_div.sv =====
// Two-stage reciprocal multiplier that turns a period in microseconds into a tick interval.
module ptb_div
   import ptb_pkg::*;
#(
   parameter int TICK_US = 31250
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [PERIOD_W-1:0] dividend,
   output logic                done,
   output logic [COUNT_W-1:0]  quotient
);

   // For every 32-bit x, floor(x / TICK_US) equals floor(x * Recip / 2^(PERIOD_W + Shift))
   // when Shift = ceil(log2(TICK_US)) and Recip is the reciprocal rounded up.
   localparam int Shift = $clog2(TICK_US);
   localparam int RecW  = PERIOD_W + 1;
   localparam int LoW   = 16;
   localparam int HiW   = RecW - LoW;
   localparam int PloW  = PERIOD_W + LoW;
   localparam int PhiW  = PERIOD_W + HiW;
   localparam int ProdW = PERIOD_W + RecW;
   localparam logic [63:0] RecipWide =
      ((64'd1 << (PERIOD_W + Shift)) + 64'(TICK_US) - 64'd1) / 64'(TICK_US);
   localparam logic [RecW-1:0] Recip   = RecipWide[RecW-1:0];
   localparam logic [HiW-1:0]  RecipHi = Recip[RecW-1:LoW];
   localparam logic [LoW-1:0]  RecipLo = Recip[LoW-1:0];

   logic                 step_ff, step_in;
   logic                 done_ff, done_in;
   logic [PloW-1:0]      plo_ff, plo_in;
   logic [PhiW-1:0]      phi_ff, phi_in;
   logic [ProdW-1:0]     prod;
   logic [PERIOD_W-1:0]  quo_ff, quo_in;

   // Full product rebuilt from the two partial products.
   assign prod = {phi_ff, LoW'(0)} + ProdW'(plo_ff);

   // First stage multiplies by both halves of the reciprocal, second stage adds and shifts.
   always_comb begin
      step_in = go;
      done_in = step_ff;
      plo_in  = plo_ff;
      phi_in  = phi_ff;
      quo_in  = quo_ff;
      if (go) begin
         plo_in = PloW'(dividend) * PloW'(RecipLo);
         phi_in = PhiW'(dividend) * PhiW'(RecipHi);
      end
      if (step_ff) begin
         quo_in = PERIOD_W'(prod >> (PERIOD_W + Shift));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      quo_ff <= quo_in;
   end

   // Clamp the interval to at least one tick and to the counter range.
   assign done = done_ff;
   always_comb begin
      if (quo_ff[PERIOD_W-1:COUNT_W] != '0) begin
         quotient = '1;
      end else if (quo_ff == '0) begin
         quotient = COUNT_W'(1);
      end else begin
         quotient = quo_ff[COUNT_W-1:0];
      end
   end

endmodule

// ===== hdl/ptb_back.sv =====
// Command executor: owns the timer state and produces one result word per command.
module ptb_back
   import ptb_pkg::*;
#(
   parameter int NUM_TIMERS = 8,
   parameter int TICK_US    = 31250
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_vld,
   input  cmd_type             head,
   output logic                pop,
   output logic                rsp_valid,
   output logic                rsp_is_expired,
   output logic                rsp_is_running,
   output logic [PERIOD_W-1:0] rsp_stored_period_us
);

   localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PtrW = $clog2(NUM_TIMERS + 1);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [PtrW-1:0]      ptr_ff, ptr_in;
   logic                 upd_vld_ff, upd_vld_in;
   logic [IdxW-1:0]      upd_idx_ff, upd_idx_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic [NUM_TIMERS-1:0] exp_ff, exp_in;
   logic [NUM_TIMERS-1:0] pvld_ff, pvld_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_exp_ff, rsp_exp_in;
   logic                 rsp_run_ff, rsp_run_in;
   logic [PERIOD_W-1:0]  rsp_per_ff, rsp_per_in;

   // Per-slot storage; count and period words live in memories.
   cnt_type              cnt_mem [NUM_TIMERS];
   logic [PERIOD_W-1:0]  period_mem [NUM_TIMERS];
   cnt_type              cnt_rd_ff;
   logic [PERIOD_W-1:0]  per_rd_ff;
   logic [IdxW-1:0]      rd_addr;
   logic                 cnt_we;
   logic [IdxW-1:0]      cnt_wa;
   cnt_type              cnt_wd;
   logic                 per_we;

   logic [IdxW-1:0]      head_slot;
   logic [IdxW-1:0]      cmd_slot;
   logic                 div_go;
   logic                 div_done;
   logic [COUNT_W-1:0]   div_quo;

   assign head_slot = IdxW'(head.slot);
   assign cmd_slot  = IdxW'(cmd_ff.slot);
   assign rd_addr   = (state_ff == B_SWEEP) ? ptr_ff[IdxW-1:0] : head_slot;

   // Interval divider for start commands.
   ptb_div #(
      .TICK_US (TICK_US)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (head.period),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state, slot updates and the result word.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ptr_in       = ptr_ff;
      upd_vld_in   = 1'b0;
      upd_idx_in   = upd_idx_ff;
      run_in       = run_ff;
      exp_in       = exp_ff;
      pvld_in      = pvld_ff;
      rsp_valid_in = 1'b0;
      rsp_exp_in   = 1'b0;
      rsp_run_in   = 1'b0;
      rsp_per_in   = '0;
      pop          = 1'b0;
      div_go       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wa       = upd_idx_ff;
      cnt_wd       = cnt_rd_ff;
      per_we       = 1'b0;

      // Tick sweep back half: apply elapsed ticks to the slot read last cycle.
      if (upd_vld_ff && run_ff[upd_idx_ff]) begin
         cnt_we = 1'b1;
         if ({2'b00, cmd_ff.elapsed} >= cnt_rd_ff.remain) begin
            cnt_wd.remain       = cnt_rd_ff.reload;
            exp_in[upd_idx_ff]  = 1'b1;
         end else begin
            cnt_wd.remain = cnt_rd_ff.remain - {2'b00, cmd_ff.elapsed};
         end
      end

      case (state_ff)
         B_IDLE: begin
            if (head_vld) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.kind)
                  K_TICK: begin
                     ptr_in   = '0;
                     state_in = B_SWEEP;
                  end
                  K_START: begin
                     div_go   = 1'b1;
                     state_in = B_DIV;
                  end
                  K_STOP: begin
                     run_in[head_slot] = 1'b0;
                     rsp_valid_in      = 1'b1;
                  end
                  K_QRUN: begin
                     rsp_run_in   = run_ff[head_slot];
                     rsp_valid_in = 1'b1;
                  end
                  K_QEXP: begin
                     rsp_exp_in        = exp_ff[head_slot];
                     exp_in[head_slot] = 1'b0;
                     rsp_valid_in      = 1'b1;
                  end
                  K_QPER: begin
                     state_in = B_QPER;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         B_SWEEP: begin
            // Front half reads one slot per cycle until all are issued.
            if (ptr_ff == PtrW'(NUM_TIMERS)) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end else begin
               upd_vld_in = 1'b1;
               upd_idx_in = ptr_ff[IdxW-1:0];
               ptr_in     = ptr_ff + PtrW'(1);
            end
         end
         B_DIV: begin
            if (div_done) begin
               cnt_we           = 1'b1;
               cnt_wa           = cmd_slot;
               cnt_wd.reload    = div_quo;
               cnt_wd.remain    = div_quo;
               per_we           = 1'b1;
               run_in[cmd_slot]  = 1'b1;
               exp_in[cmd_slot]  = 1'b0;
               pvld_in[cmd_slot] = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = B_IDLE;
            end
         end
         B_QPER: begin
            rsp_per_in   = pvld_ff[cmd_slot] ? per_rd_ff : '0;
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         ptr_ff       <= '0;
         upd_vld_ff   <= 1'b0;
         run_ff       <= '0;
         exp_ff       <= '0;
         pvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         upd_vld_ff   <= upd_vld_in;
         run_ff       <= run_in;
         exp_ff       <= exp_in;
         pvld_ff      <= pvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      upd_idx_ff <= upd_idx_in;
      rsp_exp_ff <= rsp_exp_in;
      rsp_run_ff <= rsp_run_in;
      rsp_per_ff <= rsp_per_in;
   end

   // Count memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   // Period memory: written by start, read for period queries.
   always_ff @(posedge clock) begin
      if (per_we) begin
         period_mem[cmd_slot] <= cmd_ff.period;
      end
      per_rd_ff <= period_mem[rd_addr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_expired       = rsp_exp_ff;
   assign rsp_is_running       = rsp_run_ff;
   assign rsp_stored_period_us = rsp_per_ff;

`ifndef SYNTHESIS
   // The sweep pointer never exceeds NUM_TIMERS, one past the last slot.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SWEEP) |-> (ptr_ff <= PtrW'(NUM_TIMERS)))
      else $error("tick sweep pointer out of range");

   // The divider only finishes while a start command waits for it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == B_DIV))
      else $error("divider finished outside a start command");

   // No result word is issued while a start still waits on the divider.
   a_div_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && !div_done) |=> !rsp_valid_ff)
      else $error("result issued before the interval was ready");

   // A slot update only comes from a sweep in progress.
   a_upd_in_sweep: assert property (@(posedge clock) disable iff (reset)
      upd_vld_ff |-> (state_ff == B_SWEEP))
      else $error("slot update outside a tick sweep");
`endif

endmodule

// ===== tb/tb_periodic_timer_bank_core.sv =====
// Self-checking testbench for the periodic timer bank: directed table, then random commands.
module tb_periodic_timer_bank_core
   import ptb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_SLOTS  = 8;
   localparam int unsigned TICK_US    = 31250;
   localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
   localparam int          MAX_REPORT = 10;
   localparam int          RANDOM_PER_PHASE = 384;
   localparam int          NUM_PHASES = 3;
   localparam int          DRAIN_CYCLES = 24;

   // Operation codes the block does not define; they must leave the state alone.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   // One result word as the block returns it.
   typedef struct packed {
      logic                expired;
      logic                running;
      logic [PERIOD_W-1:0] period;
   } timer_reply_t;

   // One command word, with an optional hand-written expected reply.
   typedef struct {
      logic [OP_W-1:0]      op;
      logic [IDX_W-1:0]     idx;
      logic [PERIOD_W-1:0]  period;
      logic [ELAPSED_W-1:0] elapsed;
      bit                   fixed;
      timer_reply_t         reply;
   } timer_cmd_t;

   localparam timer_reply_t NO_REPLY = '{1'b0, 1'b0, 32'd0};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_operation;
   logic [IDX_W-1:0]     req_timer_index;
   logic [PERIOD_W-1:0]  req_period_us;
   logic [ELAPSED_W-1:0] req_elapsed_ticks;
   logic                 rsp_valid;
   logic                 rsp_is_expired;
   logic                 rsp_is_running;
   logic [PERIOD_W-1:0]  rsp_stored_period_us;

   // Hand-written reply for the word currently on the request port.
   bit           cur_fixed;
   timer_reply_t cur_reply;

   // Shadow copy of the timer bank.
   logic [PERIOD_W-1:0] shadow_period [NUM_SLOTS];
   logic [COUNT_W-1:0]  shadow_reload [NUM_SLOTS];
   logic [COUNT_W-1:0]  shadow_remain [NUM_SLOTS];
   logic                shadow_running [NUM_SLOTS];
   logic                shadow_expired [NUM_SLOTS];

   timer_reply_t pending_replies [$];
   int           mismatch_count;
   int           idle_pct;

   // Directed words: reset values, period extremes, interval rounding, zero and
   // huge elapsed counts, expiry latch and its clear, stop keeping expiry, spare codes.
   timer_cmd_t directed_cmds [25] = '{
      '{OP_QRUN,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_QEXP,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_QPER,    3'd7, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_TICK,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_START,   3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_QRUN,    3'd0, 32'd0,          16'd0,     1'b1, '{1'b0, 1'b1, 32'd0}},
      '{OP_TICK,    3'd0, 32'd0,          16'd1,     1'b1, NO_REPLY},
      '{OP_QEXP,    3'd0, 32'd0,          16'd0,     1'b1, '{1'b1, 1'b0, 32'd0}},
      '{OP_QEXP,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_START,   3'd1, 32'hFFFF_FFFF,  16'd0,     1'b1, NO_REPLY},
      '{OP_QPER,    3'd1, 32'd0,          16'd0,     1'b1, '{1'b0, 1'b0, 32'hFFFF_FFFF}},
      '{OP_START,   3'd2, 32'd31249,      16'd0,     1'b1, NO_REPLY},
      '{OP_START,   3'd3, 32'd31250,      16'd0,     1'b1, NO_REPLY},
      '{OP_START,   3'd4, 32'd62500,      16'd0,     1'b1, NO_REPLY},
      '{OP_TICK,    3'd0, 32'd0,          16'd1,     1'b0, NO_REPLY},
      '{OP_QEXP,    3'd4, 32'd0,          16'd0,     1'b0, NO_REPLY},
      '{OP_TICK,    3'd0, 32'd0,          16'hFFFF,  1'b1, NO_REPLY},
      '{OP_QEXP,    3'd4, 32'd0,          16'd0,     1'b1, '{1'b1, 1'b0, 32'd0}},
      '{OP_QEXP,    3'd1, 32'd0,          16'd0,     1'b0, NO_REPLY},
      '{OP_STOP,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_QRUN,    3'd0, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_QEXP,    3'd0, 32'd0,          16'd0,     1'b0, NO_REPLY},
      '{OP_STOP,    3'd7, 32'd0,          16'd0,     1'b1, NO_REPLY},
      '{OP_SPARE_A, 3'd5, 32'hFFFF_FFFF,  16'hFFFF,  1'b1, NO_REPLY},
      '{OP_SPARE_B, 3'd2, 32'hFFFF_FFFF,  16'hFFFF,  1'b1, NO_REPLY}
   };

   periodic_timer_bank_core #(
      .NUM_TIMERS (NUM_SLOTS),
      .TICK_US    (TICK_US)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_timer_index      (req_timer_index),
      .req_period_us        (req_period_us),
      .req_elapsed_ticks    (req_elapsed_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_is_expired       (rsp_is_expired),
      .rsp_is_running       (rsp_is_running),
      .rsp_stored_period_us (rsp_stored_period_us)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Reload interval in base ticks for a period, clamped to at least one tick
   // and to the width of the count registers.
   function automatic logic [COUNT_W-1:0] reload_ticks(logic [PERIOD_W-1:0] period);
      logic [PERIOD_W-1:0] quot;
      quot = period / TICK_US;
      if (quot < 1) quot = PERIOD_W'(1);
      if (quot > COUNT_MAX) quot = COUNT_MAX;
      return quot[COUNT_W-1:0];
   endfunction

   // Applies one accepted word to the shadow bank and returns the reply it causes.
   function automatic timer_reply_t apply_timer_command(logic [OP_W-1:0] op,
                                                        logic [IDX_W-1:0] idx,
                                                        logic [PERIOD_W-1:0] period,
                                                        logic [ELAPSED_W-1:0] elapsed);
      timer_reply_t reply;
      logic [COUNT_W-1:0] step;
      reply = NO_REPLY;
      step  = COUNT_W'(elapsed);
      if (op == OP_TICK) begin
         if (elapsed != 0) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (shadow_reload[s] != 0) begin
                  if (step >= shadow_remain[s]) begin
                     shadow_remain[s]  = shadow_reload[s];
                     shadow_expired[s] = 1'b1;
                  end else begin
                     shadow_remain[s] = shadow_remain[s] - step;
                  end
               end
            end
         end
      end else if (int'(idx) < NUM_SLOTS) begin
         case (op)
            OP_START: begin
               shadow_period[idx]  = period;
               shadow_reload[idx]  = reload_ticks(period);
               shadow_remain[idx]  = shadow_reload[idx];
               shadow_running[idx] = 1'b1;
               shadow_expired[idx] = 1'b0;
            end
            OP_STOP: begin
               shadow_reload[idx]  = '0;
               shadow_running[idx] = 1'b0;
            end
            OP_QRUN: reply.running = shadow_running[idx];
            OP_QEXP: begin
               reply.expired       = shadow_expired[idx];
               shadow_expired[idx] = 1'b0;
            end
            OP_QPER: reply.period = shadow_period[idx];
            default: ;
         endcase
      end
      return reply;
   endfunction

   task automatic note_mismatch(string field, logic [PERIOD_W-1:0] want,
                                logic [PERIOD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORT)
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
   endtask

   // Check each result word against the oldest expectation, then record the
   // expectation of any word accepted at this edge.
   always @(posedge clock) begin
      timer_reply_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               note_mismatch("unexpected result word", '0, rsp_stored_period_us);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_is_expired !== want.expired)
                  note_mismatch("is_expired", PERIOD_W'(want.expired),
                                PERIOD_W'(rsp_is_expired));
               if (rsp_is_running !== want.running)
                  note_mismatch("is_running", PERIOD_W'(want.running),
                                PERIOD_W'(rsp_is_running));
               if (rsp_stored_period_us !== want.period)
                  note_mismatch("stored_period_us", want.period, rsp_stored_period_us);
            end
         end
         if (start && !busy) begin
            want = apply_timer_command(req_operation, req_timer_index, req_period_us,
                                       req_elapsed_ticks);
            pending_replies.push_back(cur_fixed ? cur_reply : want);
         end
      end
   end

   // Drive one word at the falling edge, after an optional idle gap, and hold it
   // until the block takes it.
   task automatic send_word(timer_cmd_t cmd);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(5)) @(negedge clock);
      end
      @(negedge clock);
      start             = 1'b1;
      req_operation     = cmd.op;
      req_timer_index   = cmd.idx;
      req_period_us     = cmd.period;
      req_elapsed_ticks = cmd.elapsed;
      cur_fixed         = cmd.fixed;
      cur_reply         = cmd.reply;
      do @(posedge clock); while (busy);
   endtask

   // Random word: mostly short intervals and small tick steps so that timers
   // actually count down and expire, with full-range values mixed in.
   function automatic timer_cmd_t random_word();
      timer_cmd_t cmd;
      int unsigned pick;
      cmd.fixed   = 1'b0;
      cmd.reply   = NO_REPLY;
      cmd.idx     = IDX_W'($urandom_range(NUM_SLOTS - 1));
      cmd.period  = $urandom;
      cmd.elapsed = ELAPSED_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 30)      cmd.op = OP_TICK;
      else if (pick < 50) cmd.op = OP_START;
      else if (pick < 58) cmd.op = OP_STOP;
      else if (pick < 70) cmd.op = OP_QRUN;
      else if (pick < 88) cmd.op = OP_QEXP;
      else if (pick < 98) cmd.op = OP_QPER;
      else                cmd.op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      pick = $urandom_range(99);
      if (pick < 70)
         cmd.period = $urandom_range(12 * TICK_US);
      else if (pick < 85)
         cmd.period = $urandom_range(1, 8) * TICK_US + $urandom_range(2) - 1;
      pick = $urandom_range(99);
      if (pick < 75)      cmd.elapsed = ELAPSED_W'($urandom_range(8));
      else if (pick < 85) cmd.elapsed = '0;
      return cmd;
   endfunction

   // Reset, directed table, then random phases with different idle rates.
   initial begin
      int phase_idle [NUM_PHASES];
      phase_idle        = '{0, 66, 36};
      mismatch_count    = 0;
      idle_pct          = 0;
      start             = 1'b0;
      req_operation     = OP_TICK;
      req_timer_index   = '0;
      req_period_us     = '0;
      req_elapsed_ticks = '0;
      cur_fixed         = 1'b0;
      cur_reply         = NO_REPLY;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         shadow_period[s]  = '0;
         shadow_reload[s]  = '0;
         shadow_remain[s]  = '0;
         shadow_running[s] = 1'b0;
         shadow_expired[s] = 1'b0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_cmds[i]) send_word(directed_cmds[i]);
      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = phase_idle[p];
         repeat (RANDOM_PER_PHASE) send_word(random_word());
      end
      @(negedge clock);
      start = 1'b0;

      // Drain outstanding results, then give stray words time to show up.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog for a hung handshake or lost result words.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== periodic_timer_bank_core.f =====
hdl/ptb_pkg.sv
hdl/ptb_front.sv
hdl/ptb_fifo.sv
hdl/ptb_div.sv
hdl/ptb_back.sv
hdl/periodic_timer_bank_core.sv
tb/tb_periodic_timer_bank_core.sv
